@@ rtl/core/ehi_pkg.sv @@
// ----------------------------------------------------------------------------
// ehi_pkg
// Shared types and constants of the expiring hash index.
// ----------------------------------------------------------------------------
package ehi_pkg;

  localparam int EhiCapacity = 256;
  localparam int EhiIdBytes  = 8;

  localparam logic [63:0] FnvOffset = 64'd1469598103934665603;
  localparam logic [63:0] FnvLow    = 64'd435;
  localparam logic [31:0] HitsMax   = 32'hFFFF_FFFF;

  localparam logic [2:0] ReqPut    = 3'd0;
  localparam logic [2:0] ReqLookup = 3'd1;
  localparam logic [2:0] ReqRemove = 3'd2;
  localparam logic [2:0] ReqPrune  = 3'd3;
  localparam logic [2:0] ReqClear  = 3'd4;

  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [63:0] expiry;
    logic [31:0] hits;
    logic [3:0]  kind;
  } entry_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic mod_step;
    logic probe_rd;
    logic probe_eval;
    logic sweep_rd;
    logic sweep_eval;
    logic clr_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] in_req;
    logic       in_refused;
    logic       hash_last;
    logic       mod_last;
    logic       used;
    logic       match;
    logic       probe_last;
    logic       sweep_last;
    logic       out_busy;
  } stat_t;

endpackage

@@ rtl/core/expiring_hash_index.sv @@
// ----------------------------------------------------------------------------
// expiring_hash_index
// Open-addressing table with FNV-1a hashing, linear probing and expiry prune.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          transfer
//  s_axis    in         tvalid tready tdata[135:0] tuser  request
//  m_axis    out        tvalid tready tdata[127:0]        result
//  cfg       in         cfg_valid cfg_ready cfg_data      routable mask
//
//  Put, lookup, remove: the hash takes one byte a cycle, the modulo four hash
//  bits a cycle, each probe a RAM read.
//  Prune: a read, then a write back if expired, per slot.
//  Clear: one write per slot. After reset a clearing pass runs before the
//  first request transfer.
//  A result waits in an output register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module expiring_hash_index
  import ehi_pkg::*;
#(
  parameter int CAPACITY = EhiCapacity,
  parameter int ID_BYTES = EhiIdBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_id[63:0], record_kind[67:64], time_value[131:68], zero pad
  input  logic [135:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ok[0], was_present[1], slot_index[9:2], hit_count[41:10],
  // expiry_out[105:42], kind_out[109:106], occupancy[118:110],
  // pruned_total[127:119]
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready_o = 1'b1;

  ehi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  ehi_dp #(
    .CAPACITY(CAPACITY),
    .ID_BYTES(ID_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .st_o       (st)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while busy");

  a_idle_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(cmd.probe_eval || cmd.sweep_eval || cmd.clr_wr))
    else $error("store written while idle");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !st.out_busy)
    else $error("result overwrites pending output");

endmodule

@@ rtl/core/ehi_ram.sv @@
// ----------------------------------------------------------------------------
// ehi_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ehi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ehi_ctrl.sv @@
// ----------------------------------------------------------------------------
// ehi_ctrl
// Sequencer of the expiring hash index: hash, reduce, probe and sweep steps.
// ----------------------------------------------------------------------------
module ehi_ctrl
  import ehi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t st_i,
  output cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_INIT = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_HASH = 10'b00_0000_0100,
    S_MOD  = 10'b00_0000_1000,
    S_PRD  = 10'b00_0001_0000,
    S_PEV  = 10'b00_0010_0000,
    S_CLR  = 10'b00_0100_0000,
    S_SRD  = 10'b00_1000_0000,
    S_SEV  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_wr = 1'b1;
        if (st_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (st_i.in_req)
            ReqPut:    state_d = st_i.in_refused ? S_DONE : S_HASH;
            ReqLookup: state_d = S_HASH;
            ReqRemove: state_d = S_HASH;
            ReqPrune:  state_d = S_SRD;
            ReqClear:  state_d = S_CLR;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (st_i.hash_last) state_d = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (st_i.mod_last) state_d = S_PRD;
      end
      S_PRD: begin
        cmd_o.probe_rd = 1'b1;
        state_d        = S_PEV;
      end
      S_PEV: begin
        cmd_o.probe_eval = 1'b1;
        if (!st_i.used || st_i.match || st_i.probe_last) state_d = S_DONE;
        else state_d = S_PRD;
      end
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (st_i.sweep_last) state_d = S_DONE;
      end
      S_SRD: begin
        cmd_o.sweep_rd = 1'b1;
        state_d        = S_SEV;
      end
      S_SEV: begin
        cmd_o.sweep_eval = 1'b1;
        state_d = st_i.sweep_last ? S_DONE : S_SRD;
      end
      S_DONE: begin
        if (!st_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/ehi_dp.sv @@
// ----------------------------------------------------------------------------
// ehi_dp
// Datapath: request registers, FNV-1a hash, modulo unit, slot store, result.
// ----------------------------------------------------------------------------
module ehi_dp
  import ehi_pkg::*;
#(
  parameter int CAPACITY = EhiCapacity,
  parameter int ID_BYTES = EhiIdBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [2:0]   in_req_i,
  input  logic [135:0] in_data_i,
  input  logic         cfg_valid_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [127:0] out_data_o,
  input  cmd_t         cmd_i,
  output stat_t        st_o
);

  localparam int          IW      = $clog2(CAPACITY);
  localparam int          AW      = IW + 3;
  localparam int          CW      = $clog2(CAPACITY + 1);
  localparam logic [63:0] KeyMask = {64{1'b1}} >> (64 - 8 * ID_BYTES);

  logic [15:0]   mask_q;
  logic [2:0]    req_q;
  logic [63:0]   key_q, time_q, h_q, h_d, hx;
  logic [3:0]    kind_q;
  logic [2:0]    byte_q;
  logic [3:0]    nib_q;
  logic [IW-1:0] rem_q, rem_d;
  logic [IW-1:0] wgt [64];
  logic [AW-1:0] acc_s, red4, red2;
  logic [IW-1:0] p_q, p_inc, n_q;
  logic [CW-1:0] count_q, pruned_q;
  logic          res_ok_q, res_pres_q;
  logic [IW-1:0] res_slot_q;
  logic [31:0]   res_hits_q;
  logic [63:0]   res_exp_q;
  logic [3:0]    res_kind_q;
  logic          out_valid_q;
  logic [127:0]  out_data_q;
  logic          we, is_put, is_rem, expired, full, count_pos;
  entry_t        rd, wd, upd;

  assign is_put    = req_q == ReqPut;
  assign is_rem    = req_q == ReqRemove;
  assign full      = count_q >= CW'(CAPACITY);
  assign count_pos = count_q != '0;
  assign p_inc     = (p_q == IW'(CAPACITY - 1)) ? '0 : p_q + 1'b1;
  assign expired   = rd.used && (rd.expiry <= time_q);

  assign hx    = h_q ^ {56'b0, key_q[{byte_q, 3'b000} +: 8]};
  assign h_d   = {hx[23:0], 40'b0} + (hx * FnvLow);

  for (genvar j = 0; j < 64; j++) begin : g_wgt
    localparam logic [63:0] Pw = (64'd1 << j) % 64'(CAPACITY);
    assign wgt[j] = h_q[j] ? Pw[IW-1:0] : '0;
  end

  assign acc_s = AW'(rem_q) + AW'(wgt[{nib_q, 2'd0}]) + AW'(wgt[{nib_q, 2'd1}])
               + AW'(wgt[{nib_q, 2'd2}]) + AW'(wgt[{nib_q, 2'd3}]);
  assign red4  = (acc_s >= AW'(4 * CAPACITY)) ? acc_s - AW'(4 * CAPACITY) : acc_s;
  assign red2  = (red4 >= AW'(2 * CAPACITY)) ? red4 - AW'(2 * CAPACITY) : red4;
  assign rem_d = (red2 >= AW'(CAPACITY)) ? IW'(red2 - AW'(CAPACITY)) : red2[IW-1:0];

  always_comb begin
    upd        = rd;
    upd.hits   = (rd.hits != HitsMax) ? rd.hits + 32'd1 : rd.hits;
    upd.expiry = (time_q > rd.expiry) ? time_q : rd.expiry;
  end

  always_comb begin
    we = 1'b0;
    wd = '0;
    if (cmd_i.clr_wr) begin
      we = 1'b1;
    end else if (cmd_i.sweep_eval) begin
      we = expired;
    end else if (cmd_i.probe_eval) begin
      if (!rd.used) begin
        we = is_put && !full;
        wd = '{used: 1'b1, key: key_q, expiry: time_q, hits: 32'd1, kind: kind_q};
      end else if (st_o.match) begin
        we = is_put || is_rem;
        wd = is_put ? upd : '0;
      end
    end
  end

  ehi_ram #(
    .Width($bits(entry_t)),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(p_q),
    .wdata_i(wd),
    .re_i   (cmd_i.probe_rd | cmd_i.sweep_rd),
    .raddr_i(p_q),
    .rdata_o(rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= 16'hFFFF;
      p_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) mask_q <= cfg_data_i;
      if (cmd_i.load) p_q <= '0;
      if (cmd_i.mod_step && nib_q == 4'hF) p_q <= rem_d;
      if (cmd_i.clr_wr || cmd_i.sweep_eval) p_q <= p_inc;
      if (cmd_i.probe_eval && rd.used && !st_o.match) p_q <= p_inc;
      if (cmd_i.clr_wr) count_q <= '0;
      if (cmd_i.sweep_eval && expired && count_pos) count_q <= count_q - 1'b1;
      if (cmd_i.probe_eval && !rd.used && is_put && !full) count_q <= count_q + 1'b1;
      if (cmd_i.probe_eval && st_o.match && is_rem && count_pos) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q      <= in_req_i;
      key_q      <= in_data_i[63:0] & KeyMask;
      kind_q     <= in_data_i[67:64];
      time_q     <= in_data_i[131:68];
      h_q        <= FnvOffset;
      byte_q     <= '0;
      nib_q      <= '0;
      rem_q      <= '0;
      res_ok_q   <= (in_req_i == ReqPrune) || (in_req_i == ReqClear);
      res_pres_q <= 1'b0;
      res_slot_q <= '0;
      res_hits_q <= '0;
      res_exp_q  <= '0;
      res_kind_q <= '0;
      pruned_q   <= '0;
    end
    if (cmd_i.hash_step) begin
      h_q    <= h_d;
      byte_q <= byte_q + 3'd1;
    end
    if (cmd_i.mod_step) begin
      rem_q <= rem_d;
      nib_q <= nib_q + 4'd1;
      n_q   <= '0;
    end
    if (cmd_i.probe_eval) begin
      n_q <= n_q + 1'b1;
      if ((!rd.used && is_put && !full) || st_o.match) begin
        res_ok_q   <= 1'b1;
        res_pres_q <= st_o.match;
        res_slot_q <= p_q;
        res_hits_q <= st_o.match ? (is_put ? upd.hits : rd.hits) : 32'd1;
        res_exp_q  <= st_o.match ? (is_put ? upd.expiry : rd.expiry) : time_q;
        res_kind_q <= st_o.match ? rd.kind : kind_q;
      end
    end
    if (cmd_i.sweep_eval && expired) pruned_q <= pruned_q + 1'b1;
    if (cmd_i.finish) begin
      out_data_q <= {9'(pruned_q), 9'(count_q), res_kind_q, res_exp_q, res_hits_q,
                     8'(res_slot_q), res_pres_q, res_ok_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign st_o.in_req     = in_req_i;
  assign st_o.in_refused = !mask_q[in_data_i[67:64]];
  assign st_o.hash_last  = byte_q == 3'(ID_BYTES - 1);
  assign st_o.mod_last   = nib_q == 4'hF;
  assign st_o.used       = rd.used;
  assign st_o.match      = rd.used && (rd.key == key_q);
  assign st_o.probe_last = n_q == IW'(CAPACITY - 1);
  assign st_o.sweep_last = p_q == IW'(CAPACITY - 1);
  assign st_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

@@ verif/tb_expiring_hash_index.sv @@
// ----------------------------------------------------------------------------
// tb_expiring_hash_index
// Self-checking bench for the expiring hash index. Requests are driven over
// the slave stream with random gaps, results are drained with random stalls,
// and a scoreboard keeps its own table copy (FNV-1a home slot, linear probe)
// to predict every result field in order. Covers put, lookup, remove, prune,
// clear, refused types, full table, unknown requests and mask changes.
// ----------------------------------------------------------------------------
module tb_expiring_hash_index
  import ehi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          Slots    = 256;
  localparam logic [63:0] FnvPrime = 64'd1099511628211;
  localparam logic [63:0] TimeMax  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [2:0]  ReqOdd5  = 3'd5;
  localparam logic [2:0]  ReqOdd6  = 3'd6;
  localparam logic [2:0]  ReqOdd7  = 3'd7;

  typedef struct packed {
    logic [8:0]  pruned_total;
    logic [8:0]  occupancy;
    logic [3:0]  kind_out;
    logic [63:0] expiry_out;
    logic [31:0] hit_count;
    logic [7:0]  slot_index;
    logic        was_present;
    logic        ok;
  } result_t;

  class hash_index_scoreboard;
    bit          used[Slots];
    logic [63:0] key_q[Slots];
    logic [63:0] expiry_q[Slots];
    logic [31:0] hits_q[Slots];
    logic [3:0]  kind_q[Slots];
    int          entries;
    logic [15:0] mask;
    result_t     expected_q[$];
    int          errors;

    function new();
      mask = 16'hFFFF;
      entries = 0;
      errors = 0;
      wipe_all();
    endfunction

    function void wipe(int p);
      used[p] = 0;
      key_q[p] = '0;
      expiry_q[p] = '0;
      hits_q[p] = '0;
      kind_q[p] = '0;
    endfunction

    function void wipe_all();
      for (int i = 0; i < Slots; i++) wipe(i);
    endfunction

    function logic [7:0] home_slot(logic [63:0] k);
      logic [63:0] h;
      h = FnvOffset;
      for (int i = 0; i < 8; i++) begin
        h = h ^ {56'd0, k[8*i +: 8]};
        h = h * FnvPrime;
      end
      return h[7:0];
    endfunction

    // returns 1 when the walk stops; pos and hit tell where and why
    function bit walk(logic [63:0] k, output int pos, output bit hit);
      int p;
      p = home_slot(k);
      pos = 0;
      hit = 0;
      for (int n = 0; n < Slots; n++) begin
        if (!used[p]) begin
          pos = p;
          return 1;
        end
        if (key_q[p] == k) begin
          pos = p;
          hit = 1;
          return 1;
        end
        p = (p + 1) % Slots;
      end
      return 0;
    endfunction

    function void fill_entry(ref result_t r, input int p);
      r.slot_index = p[7:0];
      r.hit_count = hits_q[p];
      r.expiry_out = expiry_q[p];
      r.kind_out = kind_q[p];
    endfunction

    function void note_request(logic [2:0] req, logic [63:0] k, logic [3:0] kd,
                               logic [63:0] tv);
      result_t r;
      int      pos;
      bit      hit;
      int      pruned;
      r = '0;
      pruned = 0;
      case (req)
        ReqPut: begin
          if (mask[kd] && walk(k, pos, hit)) begin
            if (hit) begin
              if (hits_q[pos] != HitsMax) hits_q[pos]++;
              if (tv > expiry_q[pos]) expiry_q[pos] = tv;
              r.ok = 1;
              r.was_present = 1;
              fill_entry(r, pos);
            end else if (entries < Slots) begin
              used[pos] = 1;
              key_q[pos] = k;
              expiry_q[pos] = tv;
              hits_q[pos] = 1;
              kind_q[pos] = kd;
              entries++;
              r.ok = 1;
              fill_entry(r, pos);
            end
          end
        end
        ReqLookup, ReqRemove: begin
          if (walk(k, pos, hit) && hit) begin
            r.ok = 1;
            r.was_present = 1;
            fill_entry(r, pos);
            if (req == ReqRemove) begin
              wipe(pos);
              if (entries > 0) entries--;
            end
          end
        end
        ReqPrune: begin
          for (int i = 0; i < Slots; i++) begin
            if (used[i] && expiry_q[i] <= tv) begin
              wipe(i);
              pruned++;
              if (entries > 0) entries--;
            end
          end
          r.ok = 1;
          r.pruned_total = pruned[8:0];
        end
        ReqClear: begin
          wipe_all();
          entries = 0;
          r.ok = 1;
        end
        default: ;
      endcase
      r.occupancy = entries[8:0];
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      compare_field("ok", got.ok, want.ok);
      compare_field("was_present", got.was_present, want.was_present);
      compare_field("slot_index", got.slot_index, want.slot_index);
      compare_field("hit_count", got.hit_count, want.hit_count);
      compare_field("expiry_out", got.expiry_out, want.expiry_out);
      compare_field("kind_out", got.kind_out, want.kind_out);
      compare_field("occupancy", got.occupancy, want.occupancy);
      compare_field("pruned_total", got.pruned_total, want.pruned_total);
    endtask
  endclass

  logic         clk_i = 0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i;

  hash_index_scoreboard board = new();
  logic [63:0] key_pool[40];
  int          rx_hold;
  bit          steady;

  expiring_hash_index DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(logic [2:0] req, logic [63:0] k, logic [3:0] kd,
                              logic [63:0] tv);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= req;
    s_axis_tdata <= {4'd0, tv, kd, k};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(req, k, kd, tv);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [15:0] m);
    drain();
    @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.mask = m;
    cfg_valid_i <= 0;
  endtask

  task automatic random_request();
    int          r;
    logic [63:0] k;
    logic [63:0] tv;
    r = $urandom_range(0, 999);
    k = key_pool[$urandom_range(0, 39)];
    case ($urandom_range(0, 9))
      0: tv = '0;
      1: tv = {$urandom, $urandom};
      default: tv = 64'($urandom_range(0, 2000));
    endcase
    if (r < 450) send_request(ReqPut, k, 4'($urandom_range(0, 15)), tv);
    else if (r < 680) send_request(ReqLookup, k, 4'($urandom), {$urandom, $urandom});
    else if (r < 820) send_request(ReqRemove, k, 4'($urandom), {$urandom, $urandom});
    else if (r < 880) send_request(ReqPrune, {$urandom, $urandom}, 4'($urandom), tv);
    else if (r < 900) send_request(ReqClear, {$urandom, $urandom}, 4'($urandom), tv);
    else if (r < 930) send_request(3'($urandom_range(5, 7)), k, 4'($urandom), tv);
    else send_request(ReqLookup, {$urandom, $urandom}, 4'($urandom), tv);
  endtask

  initial begin
    int idle;
    idle = 0;
    m_axis_tready <= 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(result_t'(m_axis_tdata));
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 0;
      end else if (idle > 0) begin
        idle--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
        if (!steady) begin
          case ($urandom_range(0, 19))
            0, 1, 2: idle = $urandom_range(1, 3);
            3: idle = $urandom_range(15, 80);
            default: idle = 0;
          endcase
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb_expiring_hash_index: done, errors");
    $finish;
  end

  initial begin
    int waited;
    rst_ni <= 0;
    s_axis_tvalid <= 0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_valid_i <= 0;
    cfg_data_i <= '0;
    rx_hold = 0;
    steady = 0;
    key_pool[0] = '0;
    key_pool[1] = TimeMax;
    for (int i = 2; i < 40; i++) key_pool[i] = {$urandom, $urandom};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;

    write_mask(16'hFFFF);
    send_request(ReqPut, '0, 4'd0, '0);
    send_request(ReqPut, TimeMax, 4'd15, TimeMax);
    send_request(ReqPut, TimeMax, 4'd3, 64'd5);
    send_request(ReqPut, '0, 4'd7, 64'd100);
    send_request(ReqLookup, TimeMax, 4'd0, '0);
    send_request(ReqLookup, key_pool[2], 4'd0, '0);
    send_request(ReqRemove, '0, 4'd0, '0);
    send_request(ReqRemove, '0, 4'd0, '0);
    send_request(ReqPut, key_pool[3], 4'd1, 64'd50);
    send_request(ReqPrune, '0, 4'd0, 64'd50);
    send_request(ReqOdd5, key_pool[4], 4'd2, 64'd9);
    send_request(ReqOdd6, TimeMax, 4'd15, TimeMax);
    send_request(ReqOdd7, '0, 4'd0, '0);
    send_request(ReqPrune, '0, 4'd0, TimeMax);
    send_request(ReqPut, key_pool[5], 4'd9, 64'd1);
    send_request(ReqClear, '0, 4'd0, '0);
    send_request(ReqLookup, key_pool[5], 4'd0, '0);

    write_mask(16'h0000);
    send_request(ReqPut, key_pool[6], 4'd0, 64'd10);
    send_request(ReqPut, key_pool[7], 4'd15, 64'd10);
    send_request(ReqLookup, key_pool[6], 4'd0, '0);

    // fill the table to capacity and beyond
    write_mask(16'hFFFF);
    steady = 1;
    for (int i = 0; i < 258; i++)
      send_request(ReqPut, {$urandom, 32'(i)}, 4'($urandom), 64'($urandom_range(0, 999)));
    steady = 0;
    send_request(ReqPut, key_pool[8], 4'd4, 64'd3);
    send_request(ReqLookup, key_pool[9], 4'd0, '0);
    rx_hold = 3000;
    for (int i = 0; i < 6; i++) send_request(ReqPut, {$urandom, 32'(i)}, 4'd2, 64'd7);
    send_request(ReqPrune, '0, 4'd0, 64'd500);
    send_request(ReqPrune, '0, 4'd0, TimeMax);

    write_mask(16'($urandom));
    for (int i = 0; i < 140; i++) random_request();
    drain();
    for (int i = 0; i < 100; i++) random_request();
    write_mask(16'h8001);
    for (int i = 0; i < 80; i++) random_request();
    write_mask(16'hFFFF);
    for (int i = 0; i < 142; i++) random_request();

    s_axis_tvalid <= 0;
    waited = 0;
    while (board.expected_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (600) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("tb_expiring_hash_index: done, clean");
    end else begin
      $display("tb_expiring_hash_index: done, errors");
    end
    $finish;
  end

endmodule
